[src/mafd_pkg.sv]
// Package for the misaligned access fixup decoder: flags, class table, stage and result types.
`default_nettype none

package mafd_pkg;

	localparam logic [7:0] FL_LOAD  = 8'h01;
	localparam logic [7:0] FL_STORE = 8'h02;
	localparam logic [7:0] FL_SEXT  = 8'h04;
	localparam logic [7:0] FL_FLOAT = 8'h08;
	localparam logic [7:0] FL_UPD   = 8'h10;
	localparam logic [7:0] FL_MULTI = 8'h20;
	localparam logic [7:0] FL_SWAP  = 8'h40;
	localparam logic [7:0] FL_HARD  = 8'h80;

	localparam logic [6:0] CLASS_DCBZ = 7'h5f;

	// word index of the index source configuration register
	localparam logic REG_INDEX_SOURCE = 1'b0;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_REFUSED   = 2'd1,
		ST_ZERO_LINE = 2'd2,
		ST_FLOAT     = 2'd3
	} status_t;

	typedef struct packed {
		logic [3:0] len;
		logic [7:0] fl;
	} class_info_t;

	typedef struct packed {
		logic [3:0]  len;
		logic [7:0]  fl;
		logic        is_dcbz;
		logic [4:0]  rd;
		logic [4:0]  ra;
		logic [31:0] addr;
		logic [31:0] mem;
		logic [31:0] rv;
	} s2_t;

	typedef struct packed {
		status_t     status;
		logic        is_store;
		logic [3:0]  access_length;
		logic [4:0]  data_reg;
		logic        reg_write_enable;
		logic [31:0] reg_write_data;
		logic [31:0] store_data;
		logic        update_enable;
		logic [4:0]  update_reg;
		logic [31:0] update_value;
		logic [31:0] zero_line_base;
	} result_t;

	function automatic class_info_t class_info(input logic [6:0] cls);
		class_info_t ci;
		ci = '0;
		unique case (cls)
			7'h00: ci = '{4'd4, FL_LOAD};
			7'h02: ci = '{4'd4, FL_STORE};
			7'h04: ci = '{4'd2, FL_LOAD};
			7'h05: ci = '{4'd2, FL_LOAD | FL_SEXT};
			7'h06: ci = '{4'd2, FL_STORE};
			7'h07: ci = '{4'd4, FL_LOAD | FL_MULTI};
			7'h08: ci = '{4'd4, FL_LOAD | FL_FLOAT | FL_SWAP};
			7'h09: ci = '{4'd8, FL_LOAD | FL_FLOAT};
			7'h0a: ci = '{4'd4, FL_STORE | FL_FLOAT | FL_SWAP};
			7'h0b: ci = '{4'd8, FL_STORE | FL_FLOAT};
			7'h10: ci = '{4'd4, FL_LOAD | FL_UPD};
			7'h12: ci = '{4'd4, FL_STORE | FL_UPD};
			7'h14: ci = '{4'd2, FL_LOAD | FL_UPD};
			7'h15: ci = '{4'd2, FL_LOAD | FL_SEXT | FL_UPD};
			7'h16: ci = '{4'd2, FL_STORE | FL_UPD};
			7'h17: ci = '{4'd4, FL_STORE | FL_MULTI};
			7'h18: ci = '{4'd4, FL_LOAD | FL_FLOAT | FL_SWAP | FL_UPD};
			7'h19: ci = '{4'd8, FL_LOAD | FL_FLOAT | FL_UPD};
			7'h1a: ci = '{4'd4, FL_STORE | FL_FLOAT | FL_SWAP | FL_UPD};
			7'h1b: ci = '{4'd8, FL_STORE | FL_FLOAT | FL_UPD};
			7'h28: ci = '{4'd0, FL_LOAD | FL_HARD};
			7'h29: ci = '{4'd0, FL_LOAD | FL_HARD};
			7'h2a: ci = '{4'd0, FL_STORE | FL_HARD};
			7'h2b: ci = '{4'd0, FL_STORE | FL_HARD};
			7'h42: ci = '{4'd0, FL_STORE | FL_HARD};
			7'h48: ci = '{4'd4, FL_LOAD | FL_SWAP};
			7'h4a: ci = '{4'd4, FL_STORE | FL_SWAP};
			7'h4c: ci = '{4'd2, FL_LOAD | FL_SWAP};
			7'h4e: ci = '{4'd2, FL_STORE | FL_SWAP};
			7'h5f: ci = '{4'd0, FL_STORE | FL_HARD};
			7'h60: ci = '{4'd4, FL_LOAD};
			7'h62: ci = '{4'd4, FL_STORE};
			7'h64: ci = '{4'd2, FL_LOAD};
			7'h65: ci = '{4'd2, FL_LOAD | FL_SEXT};
			7'h66: ci = '{4'd2, FL_STORE};
			7'h68: ci = '{4'd4, FL_LOAD | FL_FLOAT | FL_SWAP};
			7'h69: ci = '{4'd8, FL_LOAD | FL_FLOAT};
			7'h6a: ci = '{4'd4, FL_STORE | FL_FLOAT | FL_SWAP};
			7'h6b: ci = '{4'd8, FL_STORE | FL_FLOAT};
			7'h70: ci = '{4'd4, FL_LOAD | FL_UPD};
			7'h72: ci = '{4'd4, FL_STORE | FL_UPD};
			7'h74: ci = '{4'd2, FL_LOAD | FL_UPD};
			7'h75: ci = '{4'd2, FL_LOAD | FL_SEXT | FL_UPD};
			7'h76: ci = '{4'd2, FL_STORE | FL_UPD};
			7'h78: ci = '{4'd4, FL_LOAD | FL_FLOAT | FL_SWAP | FL_UPD};
			7'h79: ci = '{4'd8, FL_LOAD | FL_FLOAT | FL_UPD};
			7'h7a: ci = '{4'd4, FL_STORE | FL_FLOAT | FL_SWAP | FL_UPD};
			7'h7b: ci = '{4'd8, FL_STORE | FL_FLOAT | FL_UPD};
			default: ci = '0;
		endcase
		return ci;
	endfunction

endpackage

`default_nettype wire

[src/mafd_format.sv]
// Result formation from the looked-up class: status, load value, store data, base update, zero line base.
`default_nettype none

module mafd_format #(
	parameter int LINE_BYTES = 32
) (
	input  wire mafd_pkg::s2_t     s2,
	output mafd_pkg::result_t      res
);

	localparam int OFF_W = $clog2(LINE_BYTES);

	logic [7:0]  fl_nu;
	logic [15:0] hw;
	logic        ok;
	logic        fp;
	logic        half;

	always_comb begin
		fl_nu = s2.fl & ~mafd_pkg::FL_UPD;
		hw    = s2.mem[31:16];
		half  = (s2.len == 4'd2);
		ok    = 1'b0;
		fp    = 1'b0;
		res   = '0;
		res.status = mafd_pkg::ST_REFUSED;
		if (s2.len == 4'd0) begin
			if (s2.is_dcbz) begin
				res.status         = mafd_pkg::ST_ZERO_LINE;
				res.is_store       = 1'b1;
				res.zero_line_base = {s2.addr[31:OFF_W], OFF_W'(0)};
			end
		end else if ((s2.fl & mafd_pkg::FL_MULTI) == 8'h00) begin
			ok = 1'b1;
			case (fl_nu) inside
				mafd_pkg::FL_LOAD | mafd_pkg::FL_SEXT: begin
					res.reg_write_data   = {{16{hw[15]}}, hw};
					res.reg_write_enable = 1'b1;
				end
				mafd_pkg::FL_LOAD: begin
					res.reg_write_data   = half ? {16'h0000, hw} : s2.mem;
					res.reg_write_enable = 1'b1;
				end
				mafd_pkg::FL_LOAD | mafd_pkg::FL_SWAP: begin
					res.reg_write_data   = half ? {16'h0000, hw[7:0], hw[15:8]} :
						{s2.mem[7:0], s2.mem[15:8], s2.mem[23:16], s2.mem[31:24]};
					res.reg_write_enable = 1'b1;
				end
				mafd_pkg::FL_STORE: begin
					res.store_data = s2.rv;
				end
				mafd_pkg::FL_STORE | mafd_pkg::FL_SWAP: begin
					res.store_data = half ? {s2.rv[31:16], s2.rv[7:0], s2.rv[15:8]} :
						{s2.rv[7:0], s2.rv[15:8], s2.rv[23:16], s2.rv[31:24]};
				end
				mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT,
				mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT,
				mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT | mafd_pkg::FL_SWAP,
				mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT | mafd_pkg::FL_SWAP: begin
					fp = 1'b1;
				end
				default: begin
					ok = 1'b0;
				end
			endcase
			if (ok) begin
				res.status        = fp ? mafd_pkg::ST_FLOAT : mafd_pkg::ST_DONE;
				res.is_store      = (s2.fl & mafd_pkg::FL_STORE) != 8'h00;
				res.access_length = s2.len;
				res.data_reg      = s2.rd;
				if ((s2.fl & mafd_pkg::FL_UPD) != 8'h00) begin
					res.update_enable = 1'b1;
					res.update_reg    = s2.ra;
					res.update_value  = s2.addr;
				end
			end
		end
	end

endmodule

`default_nettype wire

[src/misaligned_access_fixup_decoder.sv]
// Top level of the misaligned access fixup decoder: index decode, table lookup, result stage.
// The three-stage pipeline registers decode, table lookup and formatting before result_valid.
// Throughput: one item per cycle unless item_stall; empty stages fill under result_stall.
// item_stall rises only when all three stages hold items and the result is stalled.
// Reset: arst_n clears the stage valid bits and index_source; payload registers are not reset.
`default_nettype none

module misaligned_access_fixup_decoder #(
	parameter int LINE_BYTES = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         item_valid,
	output logic        item_stall,
	input  wire  [31:0] instruction_word,
	input  wire  [31:0] dsisr_value,
	input  wire  [31:0] fault_address,
	input  wire  [31:0] memory_bytes,
	input  wire  [31:0] register_value,
	output logic        result_valid,
	input  wire         result_stall,
	output logic [1:0]  status,
	output logic        is_store,
	output logic [3:0]  access_length,
	output logic [4:0]  data_reg,
	output logic        reg_write_enable,
	output logic [31:0] reg_write_data,
	output logic [31:0] store_data,
	output logic        update_enable,
	output logic [4:0]  update_reg,
	output logic [31:0] update_value,
	output logic [31:0] zero_line_base
);

	localparam int OFF_W = $clog2(LINE_BYTES);

	logic index_source_q;
	logic cfg_wr;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic [6:0] cls_d;
	logic [4:0] rd_d, ra_d;

	logic [6:0]  cls_s1;
	logic [4:0]  rd_s1, ra_s1;
	logic [31:0] addr_s1, mem_s1, rv_s1;

	mafd_pkg::class_info_t ci;
	mafd_pkg::s2_t         st_s2;
	mafd_pkg::result_t     res_d;
	mafd_pkg::result_t     res_s3;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_source_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == mafd_pkg::REG_INDEX_SOURCE) begin
			index_source_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == mafd_pkg::REG_INDEX_SOURCE) begin
			prdata = {31'd0, index_source_q};
		end
	end

	// stage enables
	assign en3        = !v_s3 || !result_stall;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign item_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= item_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// class index decode
	always_comb begin
		if (!index_source_q) begin
			rd_d = instruction_word[25:21];
			ra_d = instruction_word[20:16];
			if (instruction_word[31:30] == 2'b10) begin
				cls_d = {2'b00, instruction_word[26], instruction_word[30:27]};
			end else begin
				cls_d = {instruction_word[2:1], instruction_word[6], instruction_word[10:7]};
			end
		end else begin
			rd_d  = dsisr_value[9:5];
			ra_d  = dsisr_value[4:0];
			cls_d = dsisr_value[16:10];
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && item_valid) begin
			cls_s1  <= cls_d;
			rd_s1   <= rd_d;
			ra_s1   <= ra_d;
			addr_s1 <= fault_address;
			mem_s1  <= memory_bytes;
			rv_s1   <= register_value;
		end
	end

	// table lookup
	assign ci = mafd_pkg::class_info(cls_s1);

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			st_s2.len     <= ci.len;
			st_s2.fl      <= ci.fl;
			st_s2.is_dcbz <= (cls_s1 == mafd_pkg::CLASS_DCBZ);
			st_s2.rd      <= rd_s1;
			st_s2.ra      <= ra_s1;
			st_s2.addr    <= addr_s1;
			st_s2.mem     <= mem_s1;
			st_s2.rv      <= rv_s1;
		end
	end

	// result formation
	mafd_format #(
		.LINE_BYTES(LINE_BYTES)
	) u_format (
		.s2 (st_s2),
		.res(res_d)
	);

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			res_s3 <= res_d;
		end
	end

	assign result_valid     = v_s3;
	assign status           = res_s3.status;
	assign is_store         = res_s3.is_store;
	assign access_length    = res_s3.access_length;
	assign data_reg         = res_s3.data_reg;
	assign reg_write_enable = res_s3.reg_write_enable;
	assign reg_write_data   = res_s3.reg_write_data;
	assign store_data       = res_s3.store_data;
	assign update_enable    = res_s3.update_enable;
	assign update_reg       = res_s3.update_reg;
	assign update_value     = res_s3.update_value;
	assign zero_line_base   = res_s3.zero_line_base;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (v_s1 && v_s2 && v_s3 && result_stall))
		else $error("item_stall raised with room in the pipeline");

	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == mafd_pkg::ST_REFUSED) |->
		(access_length == 4'd0 && !is_store && !update_enable && !reg_write_enable))
		else $error("refused item carries access fields");

	a_load_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && reg_write_enable) |-> (status == mafd_pkg::ST_DONE && !is_store))
		else $error("register write outside an integer load");

	a_line_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (zero_line_base[OFF_W-1:0] == '0))
		else $error("zero_line_base not line aligned");

endmodule

`default_nettype wire

[tb/sv/tb_misaligned_access_fixup_decoder.sv]
// Testbench for the misaligned access fixup decoder: directed and random items against a local model.
`timescale 1ns / 1ps

module tb_misaligned_access_fixup_decoder;

	localparam int LINE_BYTES = 32;
	localparam int IDLE_PCT = 16;
	localparam int STALL_LIMIT = 5000;
	localparam int MAX_PRINTS = 100;
	localparam int PHASE_ITEMS = 175;
	localparam int BURST_ITEMS = 150;
	localparam int SETTLE_CYCLES = 6;
	localparam logic [2:0] ADDR_INDEX_SOURCE = {mafd_pkg::REG_INDEX_SOURCE, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;
	logic        item_valid = 1'b0;
	wire         item_stall;
	logic [31:0] instruction_word = '0;
	logic [31:0] dsisr_value = '0;
	logic [31:0] fault_address = '0;
	logic [31:0] memory_bytes = '0;
	logic [31:0] register_value = '0;
	wire         result_valid;
	logic        result_stall = 1'b0;
	wire  [1:0]  status;
	wire         is_store;
	wire  [3:0]  access_length;
	wire  [4:0]  data_reg;
	wire         reg_write_enable;
	wire  [31:0] reg_write_data;
	wire  [31:0] store_data;
	wire         update_enable;
	wire  [4:0]  update_reg;
	wire  [31:0] update_value;
	wire  [31:0] zero_line_base;

	logic              decode_from_dsisr = 1'b0;
	logic              steady = 1'b0;
	int                mismatches = 0;
	int                idle_cycles = 0;
	mafd_pkg::result_t expected_results[$];

	misaligned_access_fixup_decoder #(.LINE_BYTES(LINE_BYTES)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// {length, flags} per access class
	function automatic logic [11:0] class_attrs(input logic [6:0] cls);
		case (cls)
			7'h00: return {4'd4, mafd_pkg::FL_LOAD};
			7'h02: return {4'd4, mafd_pkg::FL_STORE};
			7'h04: return {4'd2, mafd_pkg::FL_LOAD};
			7'h05: return {4'd2, mafd_pkg::FL_LOAD | mafd_pkg::FL_SEXT};
			7'h06: return {4'd2, mafd_pkg::FL_STORE};
			7'h07: return {4'd4, mafd_pkg::FL_LOAD | mafd_pkg::FL_MULTI};
			7'h08: return {4'd4, mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT | mafd_pkg::FL_SWAP};
			7'h09: return {4'd8, mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT};
			7'h0a: return {4'd4, mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT | mafd_pkg::FL_SWAP};
			7'h0b: return {4'd8, mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT};
			7'h10: return {4'd4, mafd_pkg::FL_LOAD | mafd_pkg::FL_UPD};
			7'h12: return {4'd4, mafd_pkg::FL_STORE | mafd_pkg::FL_UPD};
			7'h14: return {4'd2, mafd_pkg::FL_LOAD | mafd_pkg::FL_UPD};
			7'h15: return {4'd2, mafd_pkg::FL_LOAD | mafd_pkg::FL_SEXT | mafd_pkg::FL_UPD};
			7'h16: return {4'd2, mafd_pkg::FL_STORE | mafd_pkg::FL_UPD};
			7'h17: return {4'd4, mafd_pkg::FL_STORE | mafd_pkg::FL_MULTI};
			7'h18: return {4'd4, mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT |
				mafd_pkg::FL_SWAP | mafd_pkg::FL_UPD};
			7'h19: return {4'd8, mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT | mafd_pkg::FL_UPD};
			7'h1a: return {4'd4, mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT |
				mafd_pkg::FL_SWAP | mafd_pkg::FL_UPD};
			7'h1b: return {4'd8, mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT | mafd_pkg::FL_UPD};
			7'h28: return {4'd0, mafd_pkg::FL_LOAD | mafd_pkg::FL_HARD};
			7'h29: return {4'd0, mafd_pkg::FL_LOAD | mafd_pkg::FL_HARD};
			7'h2a: return {4'd0, mafd_pkg::FL_STORE | mafd_pkg::FL_HARD};
			7'h2b: return {4'd0, mafd_pkg::FL_STORE | mafd_pkg::FL_HARD};
			7'h42: return {4'd0, mafd_pkg::FL_STORE | mafd_pkg::FL_HARD};
			7'h48: return {4'd4, mafd_pkg::FL_LOAD | mafd_pkg::FL_SWAP};
			7'h4a: return {4'd4, mafd_pkg::FL_STORE | mafd_pkg::FL_SWAP};
			7'h4c: return {4'd2, mafd_pkg::FL_LOAD | mafd_pkg::FL_SWAP};
			7'h4e: return {4'd2, mafd_pkg::FL_STORE | mafd_pkg::FL_SWAP};
			7'h5f: return {4'd0, mafd_pkg::FL_STORE | mafd_pkg::FL_HARD};
			7'h60: return {4'd4, mafd_pkg::FL_LOAD};
			7'h62: return {4'd4, mafd_pkg::FL_STORE};
			7'h64: return {4'd2, mafd_pkg::FL_LOAD};
			7'h65: return {4'd2, mafd_pkg::FL_LOAD | mafd_pkg::FL_SEXT};
			7'h66: return {4'd2, mafd_pkg::FL_STORE};
			7'h68: return {4'd4, mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT | mafd_pkg::FL_SWAP};
			7'h69: return {4'd8, mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT};
			7'h6a: return {4'd4, mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT | mafd_pkg::FL_SWAP};
			7'h6b: return {4'd8, mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT};
			7'h70: return {4'd4, mafd_pkg::FL_LOAD | mafd_pkg::FL_UPD};
			7'h72: return {4'd4, mafd_pkg::FL_STORE | mafd_pkg::FL_UPD};
			7'h74: return {4'd2, mafd_pkg::FL_LOAD | mafd_pkg::FL_UPD};
			7'h75: return {4'd2, mafd_pkg::FL_LOAD | mafd_pkg::FL_SEXT | mafd_pkg::FL_UPD};
			7'h76: return {4'd2, mafd_pkg::FL_STORE | mafd_pkg::FL_UPD};
			7'h78: return {4'd4, mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT |
				mafd_pkg::FL_SWAP | mafd_pkg::FL_UPD};
			7'h79: return {4'd8, mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT | mafd_pkg::FL_UPD};
			7'h7a: return {4'd4, mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT |
				mafd_pkg::FL_SWAP | mafd_pkg::FL_UPD};
			7'h7b: return {4'd8, mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT | mafd_pkg::FL_UPD};
			default: return 12'h000;
		endcase
	endfunction

	function automatic mafd_pkg::result_t predict_fixup(input logic [31:0] iw, ds, addr, mem, rv);
		mafd_pkg::result_t r;
		logic [6:0]  cls;
		logic [4:0]  rd;
		logic [4:0]  ra;
		logic [3:0]  len;
		logic [7:0]  fl;
		logic [15:0] hw;
		logic        handled;
		r = '0;
		r.status = mafd_pkg::ST_REFUSED;
		handled = 1'b0;
		if (decode_from_dsisr) begin
			rd = ds[9:5];
			ra = ds[4:0];
			cls = ds[16:10];
		end else begin
			rd = iw[25:21];
			ra = iw[20:16];
			if (iw[31:30] == 2'b10)
				cls = {2'b00, iw[26], iw[30:27]};
			else
				cls = {iw[2:1], iw[6], iw[10:7]};
		end
		{len, fl} = class_attrs(cls);
		hw = mem[31:16];
		if (len == 4'd0) begin
			if (cls == mafd_pkg::CLASS_DCBZ) begin
				r.status = mafd_pkg::ST_ZERO_LINE;
				r.is_store = 1'b1;
				r.zero_line_base = addr & ~32'(LINE_BYTES - 1);
			end
		end else if ((fl & mafd_pkg::FL_MULTI) == 8'h00) begin
			handled = 1'b1;
			case (fl & ~mafd_pkg::FL_UPD)
				mafd_pkg::FL_LOAD | mafd_pkg::FL_SEXT: begin
					r.reg_write_data = {{16{hw[15]}}, hw};
					r.reg_write_enable = 1'b1;
				end
				mafd_pkg::FL_LOAD: begin
					r.reg_write_data = (len == 4'd2) ? {16'h0000, hw} : mem;
					r.reg_write_enable = 1'b1;
				end
				mafd_pkg::FL_LOAD | mafd_pkg::FL_SWAP: begin
					r.reg_write_data = (len == 4'd2) ? {16'h0000, hw[7:0], hw[15:8]} :
						{mem[7:0], mem[15:8], mem[23:16], mem[31:24]};
					r.reg_write_enable = 1'b1;
				end
				mafd_pkg::FL_STORE: r.store_data = rv;
				mafd_pkg::FL_STORE | mafd_pkg::FL_SWAP: begin
					r.store_data = (len == 4'd2) ? {rv[31:16], rv[7:0], rv[15:8]} :
						{rv[7:0], rv[15:8], rv[23:16], rv[31:24]};
				end
				mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT,
				mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT,
				mafd_pkg::FL_LOAD | mafd_pkg::FL_FLOAT | mafd_pkg::FL_SWAP,
				mafd_pkg::FL_STORE | mafd_pkg::FL_FLOAT | mafd_pkg::FL_SWAP:
					r.status = mafd_pkg::ST_FLOAT;
				default: handled = 1'b0;
			endcase
			if (handled) begin
				if (r.status != mafd_pkg::ST_FLOAT)
					r.status = mafd_pkg::ST_DONE;
				r.is_store = (fl & mafd_pkg::FL_STORE) != 8'h00;
				r.access_length = len;
				r.data_reg = rd;
				if ((fl & mafd_pkg::FL_UPD) != 8'h00) begin
					r.update_enable = 1'b1;
					r.update_reg = ra;
					r.update_value = addr;
				end
			end
		end
		return r;
	endfunction

	task automatic report_error(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got, want);
		if (got !== want)
			report_error($sformatf("%s got %h expected %h", name, got, want));
	endtask

	always @(posedge clk) begin : check_results
		mafd_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_error("result with no item outstanding");
			end else begin
				want = expected_results.pop_front();
				compare_field("status", 32'(status), 32'(want.status));
				compare_field("is_store", 32'(is_store), 32'(want.is_store));
				compare_field("access_length", 32'(access_length), 32'(want.access_length));
				compare_field("data_reg", 32'(data_reg), 32'(want.data_reg));
				compare_field("reg_write_enable", 32'(reg_write_enable),
					32'(want.reg_write_enable));
				compare_field("reg_write_data", reg_write_data, want.reg_write_data);
				compare_field("store_data", store_data, want.store_data);
				compare_field("update_enable", 32'(update_enable), 32'(want.update_enable));
				compare_field("update_reg", 32'(update_reg), 32'(want.update_reg));
				compare_field("update_value", update_value, want.update_value);
				compare_field("zero_line_base", zero_line_base, want.zero_line_base);
			end
		end
	end

	always @(negedge clk)
		result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_item(input logic [31:0] iw, ds, addr, mem, rv);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		instruction_word <= iw;
		dsisr_value <= ds;
		fault_address <= addr;
		memory_bytes <= mem;
		register_value <= rv;
		do @(posedge clk); while (item_stall);
		expected_results.push_back(predict_fixup(iw, ds, addr, mem, rv));
	endtask

	// random instruction and DSISR words that both carry the given class
	task automatic encode_class(input logic [6:0] cls, output logic [31:0] iw, ds);
		iw = $urandom;
		ds = $urandom;
		ds[16:10] = cls;
		if (cls[6:5] == 2'b00 && !cls[3] && $urandom_range(0, 1) == 1) begin
			iw[31] = 1'b1;
			iw[30:27] = cls[3:0];
			iw[26] = cls[4];
		end else begin
			if (iw[31:30] == 2'b10)
				iw[31] = 1'b0;
			iw[2:1] = cls[6:5];
			iw[6] = cls[4];
			iw[10:7] = cls[3:0];
		end
	endtask

	task automatic send_class(input logic [6:0] cls, input logic [31:0] mem);
		logic [31:0] iw;
		logic [31:0] ds;
		encode_class(cls, iw, ds);
		send_item(iw, ds, $urandom, mem, $urandom);
	endtask

	task automatic send_random_item;
		logic [6:0] cls;
		if ($urandom_range(0, 99) < 20) begin
			send_item($urandom, $urandom, $urandom, $urandom, $urandom);
		end else begin
			do cls = 7'($urandom_range(0, 127)); while (class_attrs(cls) == 12'h000);
			send_class(cls, $urandom);
		end
	endtask

	task automatic wait_results_done;
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_index_source(input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_INDEX_SOURCE;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		decode_from_dsisr = value[0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic test_directed_decode;
		send_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		send_item('1, '1, '1, '1, '1);
		send_class(7'h04, 32'h8001_2345);
		send_class(7'h05, 32'h8001_0000);
		send_class(7'h05, 32'h7fff_ffff);
		send_class(7'h06, $urandom);
		send_class(7'h4e, $urandom);
		send_class(7'h4c, 32'ha5c3_0f0f);
		send_class(7'h48, $urandom);
		send_class(7'h4a, $urandom);
		send_class(7'h02, $urandom);
		send_class(7'h07, $urandom);
		send_class(7'h17, $urandom);
		send_class(7'h09, $urandom);
		send_class(7'h1a, $urandom);
		send_class(7'h28, $urandom);
		send_class(7'h42, $urandom);
		send_class(mafd_pkg::CLASS_DCBZ, $urandom);
		send_class(7'h15, 32'hff00_1234);
		send_class(7'h01, $urandom);
	endtask

	task automatic test_directed_dsisr;
		wait_results_done();
		write_index_source(32'h1);
		// base update to r0
		send_item($urandom, {15'h0, 7'h10, 5'd7, 5'd0}, $urandom, $urandom, $urandom);
		send_item($urandom, {15'h0, mafd_pkg::CLASS_DCBZ, 10'h3ff}, '1, $urandom, $urandom);
		send_item('1, '1, '1, '1, '1);
		send_item($urandom, {15'h0, 7'h72, 5'd31, 5'd31}, $urandom, $urandom, $urandom);
		send_item('1, 32'h0, 32'h0, 32'h0, 32'h0);
	endtask

	task automatic test_random_traffic;
		logic [31:0] settings [5];
		settings = '{32'h0000_0000, 32'h0000_0001, 32'hffff_fffe, 32'hffff_ffff, 32'h8000_0001};
		for (int p = 0; p < 5; p++) begin
			wait_results_done();
			write_index_source(settings[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == PHASE_ITEMS / 2)
					wait_results_done();
				send_random_item();
			end
		end
	endtask

	task automatic test_back_to_back;
		wait_results_done();
		write_index_source(32'h0);
		steady = 1'b1;
		for (int n = 0; n < BURST_ITEMS; n++)
			send_random_item();
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_decode();
		test_directed_dsisr();
		test_random_traffic();
		test_back_to_back();
		wait_results_done();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[misaligned_access_fixup_decoder.f]
src/mafd_pkg.sv
src/mafd_format.sv
src/misaligned_access_fixup_decoder.sv
tb/sv/tb_misaligned_access_fixup_decoder.sv
